// ===== rtl/ddrf_pkg.sv =====
// Package for the delta decoder with range filter: sizes, register
// indexes and the packed payload types of the input and result channels.
// No dependencies.
package ddrf_pkg;

    localparam int LANES      = 8;
    localparam int DELTA_W    = 8;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 32;
    localparam int LANE_CNT_W = 4;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int PRE_W      = DELTA_W + $clog2(LANES);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW   = 2'd0,
        CFG_RANGE_HIGH  = 2'd1,
        CFG_START_VALUE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0]    delta_0;
        logic signed [DELTA_W-1:0]    delta_1;
        logic signed [DELTA_W-1:0]    delta_2;
        logic signed [DELTA_W-1:0]    delta_3;
        logic signed [DELTA_W-1:0]    delta_4;
        logic signed [DELTA_W-1:0]    delta_5;
        logic signed [DELTA_W-1:0]    delta_6;
        logic signed [DELTA_W-1:0]    delta_7;
        logic        [LANE_CNT_W-1:0] valid_lanes;
        logic                         first_group;
        logic                         last_group;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] decoded_value;
        logic        [CNT_W-1:0] match_count;
        logic                    is_total;
        logic                    last_of_run;
    } out_t;

endpackage

// ===== rtl/delta_decode_range_filter_top.sv =====
// Top level of the delta decoder with range filter: input register, group
// decode into a group bank, one-per-cycle result emission unless stalled.
// Depends on ddrf_pkg.
//
//  Channel   Ports                              Direction  Moves
//  input     s_valid, s_ready, s_data (in_t)    in         one group of deltas
//  result    m_valid, m_ready, m_data (out_t)   out        one match or total
//  config    cfg_we, cfg_index, cfg_wdata       in         one register write
//
// Flow: a group yields its matches, plus one total for a last group; the
// result register drains one transaction a cycle from the group bank while
// m_ready allows. Groups with at most one result stream at one per cycle
// unless stalled. An accepted group passes the input register and the group
// bank before its first result reaches the result register on m_data.
// Reset: aresetn, synchronous, active low; clears all control state, the
// running sum and count, and loads the register reset values.
// Stalls: m_ready low holds the result register; the group bank and then the
// input register fill behind it before s_ready drops.
module delta_decode_range_filter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ddrf_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ddrf_pkg::out_t                     m_data,
    input  logic                               cfg_we,
    input  logic [ddrf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddrf_pkg::VAL_W-1:0]         cfg_wdata
);
    import ddrf_pkg::*;

    // Configuration registers
    logic signed [VAL_W-1:0] range_low_reg, range_low_next;
    logic signed [VAL_W-1:0] range_high_reg, range_high_next;
    logic signed [VAL_W-1:0] start_value_reg, start_value_next;

    // Input register
    logic in_valid_reg, in_valid_next;
    in_t  in_reg;

    // Stream state
    logic signed [VAL_W-1:0] sum_reg, sum_next;
    logic        [CNT_W-1:0] cnt_reg, cnt_next;

    // Group bank: decoded values, pending matches, pending total
    logic signed [VAL_W-1:0] grp_val_reg [LANES];
    logic        [LANES-1:0] grp_mask_reg, grp_mask_next;
    logic                    grp_total_reg, grp_total_next;

    // Result register
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg;

    // Decode datapath
    logic signed [DELTA_W-1:0]  delta_arr [LANES];
    logic        [LANE_CNT_W-1:0] lanes_cl;
    logic        [LANE_CNT_W-1:0] lanes_m1;
    logic signed [VAL_W-1:0]    base_val;
    logic signed [PRE_W-1:0]    pre_sum;
    logic signed [VAL_W-1:0]    dec_val [LANES];
    logic        [LANES-1:0]    hit;
    logic signed [VAL_W-1:0]    group_end_sum;

    // Emission
    logic [LANE_IDX_W-1:0] pick_idx;
    logic [LANES-1:0]      mask_clr;
    logic                  has_match;
    logic                  busy;
    logic                  out_free;
    logic                  emit;
    logic                  emit_match;
    logic                  grp_load;
    out_t                  emit_item;

    assign delta_arr[0] = in_reg.delta_0;
    assign delta_arr[1] = in_reg.delta_1;
    assign delta_arr[2] = in_reg.delta_2;
    assign delta_arr[3] = in_reg.delta_3;
    assign delta_arr[4] = in_reg.delta_4;
    assign delta_arr[5] = in_reg.delta_5;
    assign delta_arr[6] = in_reg.delta_6;
    assign delta_arr[7] = in_reg.delta_7;

    // Clamp the lane count to the group width
    assign lanes_cl = (in_reg.valid_lanes > LANE_CNT_W'(LANES)) ?
                      LANE_CNT_W'(LANES) : in_reg.valid_lanes;
    assign lanes_m1 = lanes_cl - LANE_CNT_W'(1);

    // A first group restarts from the configured start value
    assign base_val = in_reg.first_group ? start_value_reg : sum_reg;

    // Narrow prefix sums per lane, then one wide add and range test per lane
    always_comb begin
        pre_sum = '0;
        for (int j = 0; j < LANES; j++) begin
            pre_sum    = pre_sum + PRE_W'(delta_arr[j]);
            dec_val[j] = base_val + VAL_W'(pre_sum);
            hit[j]     = (LANE_CNT_W'(j) < lanes_cl) &&
                         (dec_val[j] >= range_low_reg) &&
                         (dec_val[j] <= range_high_reg);
        end
    end

    // Sum left behind by the group: last real lane, or the base if none
    assign group_end_sum = (lanes_cl == '0) ? base_val :
                           dec_val[lanes_m1[LANE_IDX_W-1:0]];

    // Pick the lowest pending match
    always_comb begin
        pick_idx = '0;
        for (int j = LANES - 1; j >= 0; j--) begin
            if (grp_mask_reg[j]) begin
                pick_idx = LANE_IDX_W'(j);
            end
        end
        mask_clr           = grp_mask_reg;
        mask_clr[pick_idx] = 1'b0;
    end

    assign has_match = |grp_mask_reg;
    assign busy      = has_match || grp_total_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = busy && out_free;
    assign emit_match = emit && has_match;

    always_comb begin
        if (has_match) begin
            emit_item.decoded_value = grp_val_reg[pick_idx];
            emit_item.match_count   = cnt_reg;
            emit_item.is_total      = 1'b0;
            emit_item.last_of_run   = (mask_clr == '0) && !grp_total_reg;
        end else begin
            emit_item.decoded_value = '0;
            emit_item.match_count   = cnt_reg;
            emit_item.is_total      = 1'b1;
            emit_item.last_of_run   = 1'b1;
        end
    end

    // Advance a group into the bank once the bank empties, even in the cycle
    // its final result leaves
    assign grp_load = in_valid_reg && (!busy || (emit && emit_item.last_of_run));
    assign s_ready  = !in_valid_reg || grp_load;

    always_comb begin
        range_low_next   = range_low_reg;
        range_high_next  = range_high_reg;
        start_value_next = start_value_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_RANGE_LOW:   range_low_next   = cfg_wdata;
                CFG_RANGE_HIGH:  range_high_next  = cfg_wdata;
                CFG_START_VALUE: start_value_next = cfg_wdata;
                default: ;
            endcase
        end

        in_valid_next = (s_valid && s_ready) ? 1'b1 : (grp_load ? 1'b0 : in_valid_reg);

        sum_next = grp_load ? group_end_sum : sum_reg;

        // Count saturates; a first group clears it after any match leaving now
        cnt_next = cnt_reg;
        if (grp_load && in_reg.first_group) begin
            cnt_next = '0;
        end else if (emit_match && (cnt_reg != COUNT_MAX)) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (grp_load) begin
            grp_mask_next  = hit;
            grp_total_next = in_reg.last_group;
        end else begin
            grp_mask_next  = emit_match ? mask_clr : grp_mask_reg;
            grp_total_next = (emit && !has_match) ? 1'b0 : grp_total_reg;
        end

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg   <= {1'b1, {(VAL_W-1){1'b0}}};
            range_high_reg  <= {1'b0, {(VAL_W-1){1'b1}}};
            start_value_reg <= '0;
            in_valid_reg    <= 1'b0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            grp_mask_reg    <= '0;
            grp_total_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            range_low_reg   <= range_low_next;
            range_high_reg  <= range_high_next;
            start_value_reg <= start_value_next;
            in_valid_reg    <= in_valid_next;
            sum_reg         <= sum_next;
            cnt_reg         <= cnt_next;
            grp_mask_reg    <= grp_mask_next;
            grp_total_reg   <= grp_total_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (grp_load) begin
            for (int j = 0; j < LANES; j++) begin
                grp_val_reg[j] <= dec_val[j];
            end
        end
        if (emit) begin
            m_data_reg <= emit_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A total transaction always closes the run of its group
    a_total_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_total) |-> m_data.last_of_run)
        else $error("total result without last_of_run");

    // Every match shown lies inside the configured range
    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_total) |->
        ((m_data.decoded_value >= range_low_reg) &&
         (m_data.decoded_value <= range_high_reg)))
        else $error("emitted value outside range");

    // The match count only falls when a new stream starts
    a_cnt_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !(grp_load && in_reg.first_group) |=> (cnt_reg >= $past(cnt_reg)))
        else $error("match count fell without a new stream");

endmodule
